// File: design/aces_pkg.sv
`timescale 1ns / 1ps
// Shared constants, coefficient tables and stage types for the ACES tone mapper.
package aces_pkg;

    localparam int NCH       = 3;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 16;
    localparam int FRAC_W    = 16;
    localparam int V_W       = 24;
    localparam int P1_W      = 40;
    localparam int TS_W      = 40;
    localparam int MAG_W     = 49;
    localparam int DIV_STEPS = 17;
    localparam int NUM_W     = MAG_W + DIV_STEPS;
    localparam int Q_W       = 18;
    localparam int OP_W      = 2 * Q_W;
    localparam int OS_W      = OP_W + 2;

    localparam int HALF_LSB  = 32768;
    localparam int C_OFFSET_A = 1611;
    localparam int C_SUB_A    = 388853;
    localparam int C_SCALE_B  = 64470;
    localparam int C_LIN_B    = 28374;
    localparam int C_CONST_B  = 1022550109;

    // Register stages from the input of a curve lane to its output.
    localparam int CURVE_LAT = 5 + DIV_STEPS + 1;
    // Edges from the accepting edge to the edge at which the result is taken.
    localparam int LATENCY   = 3 + CURVE_LAT + 3;

    // Input matrix, row r holds the red, green and blue weights of channel r.
    localparam logic [15:0] M1_COEF [NCH][NCH] = '{
        '{16'd39137, 16'd23238, 16'd3161},
        '{16'd4981,  16'd59529, 16'd1026},
        '{16'd1861,  16'd8771,  16'd54904}
    };

    localparam logic signed [Q_W-1:0] M2_COEF [NCH][NCH] = '{
        '{18'sd105169, -18'sd34805, -18'sd4828},
        '{-18'sd6690,  18'sd72622,  -18'sd396},
        '{-18'sd214,   -18'sd4768,  18'sd70518}
    };

    typedef struct packed {
        logic           valid;
        logic [V_W-1:0] v;
    } curve_in_t;

    typedef struct packed {
        logic                  valid;
        logic signed [Q_W-1:0] q;
    } curve_out_t;

endpackage

// File: design/aces_curve.sv
`timescale 1ns / 1ps
// One channel of the fitted rational curve with a pipelined restoring divider.
module aces_curve
    import aces_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  curve_in_t  in_bus,
    output curve_out_t out_bus
);

    // Stage 1: v*(v+offset) and the scaled v for the denominator.
    logic             c1_valid_reg;
    logic [V_W-1:0]   c1_v_reg;
    logic [MAG_W-1:0] c1_num_reg;
    logic [TS_W-1:0]  c1_ts_reg;
    logic [V_W:0]     c1_vo;
    logic [MAG_W-1:0] c1_num_next;
    logic [TS_W-1:0]  c1_ts_next;

    // Stage 2: signed numerator split into sign and magnitude.
    logic             c2_valid_reg;
    logic [V_W-1:0]   c2_v_reg;
    logic [MAG_W-1:0] c2_mag_reg;
    logic             c2_pos_reg;
    logic [V_W:0]     c2_tl_reg;
    logic             c2_pos_next;
    logic [MAG_W-1:0] c2_mag_next;
    logic [TS_W-1:0]  c2_tr;
    logic [V_W:0]     c2_tl_next;

    // Stages 3 and 4: denominator.
    logic             c3_valid_reg;
    logic [MAG_W-1:0] c3_pb_reg;
    logic [MAG_W-1:0] c3_mag_reg;
    logic             c3_pos_reg;
    logic             c4_valid_reg;
    logic [MAG_W-1:0] c4_b_reg;
    logic [MAG_W-1:0] c4_mag_reg;
    logic             c4_pos_reg;

    // Divider pipeline; index 0 is loaded with the rounded dividend.
    logic [NUM_W-1:0]     d_num;
    logic [MAG_W-1:0]     d_rem_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] d_low_reg  [DIV_STEPS];
    logic [MAG_W-1:0]     d_b_reg    [DIV_STEPS];
    logic [DIV_STEPS-1:0] d_quot_reg [DIV_STEPS+1];
    logic                 d_pos_reg  [DIV_STEPS+1];
    logic                 d_valid_reg [DIV_STEPS+1];

    logic                  out_valid_reg;
    logic signed [Q_W-1:0] out_q_reg;
    logic signed [Q_W-1:0] q_mag;
    logic signed [Q_W-1:0] q_next;

    always_comb
    begin
        c1_vo       = {1'b0, in_bus.v} + (V_W+1)'(C_OFFSET_A);
        c1_num_next = MAG_W'(c1_vo) * MAG_W'(in_bus.v);
        c1_ts_next  = TS_W'(C_SCALE_B) * TS_W'(in_bus.v);
    end

    always_comb
    begin
        c2_pos_next = (c1_num_reg >= MAG_W'(C_SUB_A));
        if (c2_pos_next)
        begin
            c2_mag_next = c1_num_reg - MAG_W'(C_SUB_A);
        end
        else
        begin
            c2_mag_next = MAG_W'(C_SUB_A) - c1_num_reg;
        end
        c2_tr      = c1_ts_reg + TS_W'(HALF_LSB);
        c2_tl_next = {1'b0, c2_tr[TS_W-1:FRAC_W]} + (V_W+1)'(C_LIN_B);
    end

    // Round half up folded into the dividend: q = floor((mag*2^16 + b/2) / b).
    assign d_num = NUM_W'({c4_mag_reg, {FRAC_W{1'b0}}}) + NUM_W'(c4_b_reg >> 1);

    always_ff @(posedge clk)
    begin
        c1_v_reg   <= in_bus.v;
        c1_num_reg <= c1_num_next;
        c1_ts_reg  <= c1_ts_next;

        c2_v_reg   <= c1_v_reg;
        c2_mag_reg <= c2_mag_next;
        c2_pos_reg <= c2_pos_next;
        c2_tl_reg  <= c2_tl_next;

        c3_pb_reg  <= MAG_W'(c2_tl_reg) * MAG_W'(c2_v_reg);
        c3_mag_reg <= c2_mag_reg;
        c3_pos_reg <= c2_pos_reg;

        c4_b_reg   <= c3_pb_reg + MAG_W'(C_CONST_B);
        c4_mag_reg <= c3_mag_reg;
        c4_pos_reg <= c3_pos_reg;

        d_rem_reg[0]  <= d_num[NUM_W-1:DIV_STEPS];
        d_low_reg[0]  <= d_num[DIV_STEPS-1:0];
        d_b_reg[0]    <= c4_b_reg;
        d_quot_reg[0] <= '0;
        d_pos_reg[0]  <= c4_pos_reg;
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_div
            logic [MAG_W:0]   trial;
            logic [MAG_W:0]   diff;
            logic             ge;

            always_comb
            begin
                trial = {d_rem_reg[k], d_low_reg[k][DIV_STEPS-1]};
                diff  = trial - {1'b0, d_b_reg[k]};
                ge    = (trial >= {1'b0, d_b_reg[k]});
            end

            always_ff @(posedge clk)
            begin
                d_quot_reg[k+1] <= {d_quot_reg[k][DIV_STEPS-2:0], ge};
                d_pos_reg[k+1]  <= d_pos_reg[k];
            end

            if (k < DIV_STEPS - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    d_rem_reg[k+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                    d_low_reg[k+1] <= {d_low_reg[k][DIV_STEPS-2:0], 1'b0};
                    d_b_reg[k+1]   <= d_b_reg[k];
                end
            end
        end
    endgenerate

    always_comb
    begin
        q_mag  = {1'b0, d_quot_reg[DIV_STEPS]};
        q_next = d_pos_reg[DIV_STEPS] ? q_mag : -q_mag;
    end

    always_ff @(posedge clk)
    begin
        out_q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg  <= 1'b0;
            c2_valid_reg  <= 1'b0;
            c3_valid_reg  <= 1'b0;
            c4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                d_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            c1_valid_reg   <= in_bus.valid;
            c2_valid_reg   <= c1_valid_reg;
            c3_valid_reg   <= c2_valid_reg;
            c4_valid_reg   <= c3_valid_reg;
            d_valid_reg[0] <= c4_valid_reg;
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                d_valid_reg[i+1] <= d_valid_reg[i];
            end
            out_valid_reg  <= d_valid_reg[DIV_STEPS];
        end
    end

    assign out_bus.valid = out_valid_reg;
    assign out_bus.q     = out_q_reg;

    // The denominator always carries its constant term.
    a_denom_floor: assert property (@(posedge clk) disable iff (!rst_n)
        c4_valid_reg |-> (c4_b_reg >= MAG_W'(C_CONST_B)))
        else $error("curve denominator below its constant term");

    // The quotient must fit the divider's steps: the top of the dividend is below b.
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid_reg[0] |-> (d_rem_reg[0] < d_b_reg[0]))
        else $error("curve quotient overflows the divider");

endmodule

// File: design/aces_tone_mapping.sv
`timescale 1ns / 1ps
// A result passes the input matrix registers, the three curve lanes and the output matrix registers.
// Throughput: one item per clock; the pipeline never stalls, so busy stays low after reset.
// The depth is set mostly by the 17-stage restoring divider in each curve lane.
// Reset clears all valid bits and holds busy high; data registers are not reset.
// The receiver cannot stall: done is high for one cycle with the result.
module aces_tone_mapping
    import aces_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [IN_W-1:0]  hdr_red,
    input  logic [IN_W-1:0]  hdr_green,
    input  logic [IN_W-1:0]  hdr_blue,
    output logic             done,
    output logic [OUT_W-1:0] ldr_red,
    output logic [OUT_W-1:0] ldr_green,
    output logic [OUT_W-1:0] ldr_blue
);

    logic busy_reg;
    logic busy_next;
    logic accept;

    logic [IN_W-1:0]  hdr_in [NCH];
    logic [IN_W-1:0]  x_reg  [NCH];
    logic [P1_W-1:0]  mp_reg  [NCH][NCH];
    logic [P1_W-1:0]  mp_next [NCH][NCH];
    logic [P1_W+1:0]  vsum    [NCH];
    logic [V_W-1:0]   v_reg   [NCH];
    logic [V_W-1:0]   v_next  [NCH];
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg;

    curve_in_t             c_in  [NCH];
    curve_out_t            c_out [NCH];
    logic signed [Q_W-1:0] q_c   [NCH];
    logic                  lanes_valid;

    logic signed [OP_W-1:0] op_reg  [NCH][NCH];
    logic signed [OP_W-1:0] op_next [NCH][NCH];
    logic signed [OS_W-1:0] os_reg  [NCH];
    logic signed [OS_W-1:0] os_next [NCH];
    logic signed [OS_W-1:0] rnd     [NCH];
    logic [OUT_W-1:0]       ldr_reg  [NCH];
    logic [OUT_W-1:0]       ldr_next [NCH];
    logic o1_valid_reg, o2_valid_reg, done_reg;

    assign busy_next = 1'b0;
    assign busy      = busy_reg;
    assign accept    = start && !busy_reg;

    assign hdr_in[0] = hdr_red;
    assign hdr_in[1] = hdr_green;
    assign hdr_in[2] = hdr_blue;

    // Input matrix: products in one stage, sums and rounding to Q8.16 in the next.
    always_comb
    begin
        for (int r = 0; r < NCH; r++)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                mp_next[r][c] = P1_W'(M1_COEF[r][c]) * P1_W'(x_reg[c]);
            end
            vsum[r] = {2'b00, mp_reg[r][0]} + {2'b00, mp_reg[r][1]}
                    + {2'b00, mp_reg[r][2]} + (P1_W+2)'(HALF_LSB);
            v_next[r] = vsum[r][P1_W-1:FRAC_W];
        end
    end

    genvar g;
    generate
        for (g = 0; g < NCH; g++)
        begin : g_lane
            assign c_in[g].valid = s2_valid_reg;
            assign c_in[g].v     = v_reg[g];
            assign q_c[g]        = c_out[g].q;

            aces_curve u_curve (
                .clk     (clk),
                .rst_n   (rst_n),
                .in_bus  (c_in[g]),
                .out_bus (c_out[g])
            );
        end
    endgenerate

    assign lanes_valid = c_out[0].valid && c_out[1].valid && c_out[2].valid;

    // Output matrix, then clamp to [0,1] with rounding and saturation.
    always_comb
    begin
        for (int r = 0; r < NCH; r++)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                op_next[r][c] = M2_COEF[r][c] * q_c[c];
            end
            os_next[r] = OS_W'(op_reg[r][0]) + OS_W'(op_reg[r][1]) + OS_W'(op_reg[r][2]);
            rnd[r]     = os_reg[r] + OS_W'(HALF_LSB);
            if (os_reg[r] <= 0)
            begin
                ldr_next[r] = '0;
            end
            else if (rnd[r][OS_W-1:2*FRAC_W] != '0)
            begin
                ldr_next[r] = '1;
            end
            else
            begin
                ldr_next[r] = rnd[r][2*FRAC_W-1:FRAC_W];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < NCH; r++)
        begin
            if (accept)
            begin
                x_reg[r] <= hdr_in[r];
            end
            for (int c = 0; c < NCH; c++)
            begin
                mp_reg[r][c] <= mp_next[r][c];
                op_reg[r][c] <= op_next[r][c];
            end
            v_reg[r]   <= v_next[r];
            os_reg[r]  <= os_next[r];
            ldr_reg[r] <= ldr_next[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            o1_valid_reg <= 1'b0;
            o2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            s0_valid_reg <= accept;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            o1_valid_reg <= lanes_valid;
            o2_valid_reg <= o1_valid_reg;
            done_reg     <= o2_valid_reg;
        end
    end

    assign done      = done_reg;
    assign ldr_red   = ldr_reg[0];
    assign ldr_green = ldr_reg[1];
    assign ldr_blue  = ldr_reg[2];

    // The three curve lanes carry the same item in lockstep.
    a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (c_out[0].valid == c_out[1].valid) && (c_out[1].valid == c_out[2].valid))
        else $error("curve lanes out of step");

    // Every result traces back to an item accepted a fixed number of edges earlier.
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching accepted item");

    // Once out of reset the pipeline never refuses an item.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> !busy)
        else $error("busy raised after reset");

endmodule

// File: test/aces_tone_mapping_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ACES fitted tone mapper: directed corner and primary pixels and random pixels.
module aces_tone_mapping_tb
    import aces_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SHOW_LIMIT     = 40;

    // Input matrix in Q.16, row r gives the weights of the red, green and blue inputs.
    localparam longint M_IN [3][3] = '{
        '{39137, 23238, 3161},
        '{4981,  59529, 1026},
        '{1861,  8771,  54904}
    };
    // Output matrix in signed Q.16.
    localparam longint M_OUT [3][3] = '{
        '{105169, -34805, -4828},
        '{-6690,  72622,  -396},
        '{-214,   -4768,  70518}
    };

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } ldr_pixel_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [IN_W-1:0]  hdr_red;
    logic [IN_W-1:0]  hdr_green;
    logic [IN_W-1:0]  hdr_blue;
    logic             done;
    logic [OUT_W-1:0] ldr_red;
    logic [OUT_W-1:0] ldr_green;
    logic [OUT_W-1:0] ldr_blue;

    ldr_pixel_t pending_ldr[$];
    int         pixels_sent;
    int         pixels_directed;
    int         pixels_checked;
    int         mismatches;
    int         idle_cycles;

    aces_tone_mapping u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .hdr_red   (hdr_red),
        .hdr_green (hdr_green),
        .hdr_blue  (hdr_blue),
        .done      (done),
        .ldr_red   (ldr_red),
        .ldr_green (ldr_green),
        .ldr_blue  (ldr_blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Rational curve value in signed Q.16 for a Q8.16 input after the input matrix.
    function automatic longint rational_fit(input logic [63:0] v);
        logic signed [63:0] num;
        logic [63:0]        scaled;
        logic [63:0]        den;
        logic [63:0]        mag;
        logic [63:0]        whole;
        logic [63:0]        rem;
        logic [63:0]        frac;
        logic [63:0]        q;
        num    = $signed(v * (v + 64'd1611)) - 64'sd388853;
        scaled = (64'd64470 * v + 64'd32768) >> 16;
        den    = (scaled + 64'd28374) * v + 64'd1022550109;
        mag    = num[63] ? 64'(-num) : 64'(num);
        whole  = mag / den;
        rem    = mag % den;
        // The remainder is below 2^48, so the shifted value still fits in 64 bits.
        frac   = ((rem << 16) + (den >> 1)) / den;
        q      = (whole << 16) + frac;
        return num[63] ? -longint'(q) : longint'(q);
    endfunction

    function automatic ldr_pixel_t tone_map(input logic [IN_W-1:0] r,
                                            input logic [IN_W-1:0] g,
                                            input logic [IN_W-1:0] b);
        logic [63:0]        x [3];
        logic [63:0]        acc;
        longint             q [3];
        logic signed [63:0] mix;
        logic [63:0]        lvl [3];
        ldr_pixel_t         px;
        x[0] = 64'(r);
        x[1] = 64'(g);
        x[2] = 64'(b);
        for (int row = 0; row < 3; row++)
        begin
            acc = 64'd0;
            for (int col = 0; col < 3; col++)
                acc += 64'(M_IN[row][col]) * x[col];
            q[row] = rational_fit((acc + 64'd32768) >> 16);
        end
        for (int row = 0; row < 3; row++)
        begin
            mix = 64'sd0;
            for (int col = 0; col < 3; col++)
                mix += M_OUT[row][col] * q[col];
            if (mix <= 0)
                lvl[row] = 64'd0;
            else
            begin
                lvl[row] = (64'(mix) + 64'd32768) >> 16;
                if (lvl[row] > 64'd65535)
                    lvl[row] = 64'd65535;
            end
        end
        px.red   = lvl[0][OUT_W-1:0];
        px.green = lvl[1][OUT_W-1:0];
        px.blue  = lvl[2][OUT_W-1:0];
        return px;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < SHOW_LIMIT)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Drives one item and holds it until the block takes it.
    task automatic send_pixel(input logic [IN_W-1:0] r,
                              input logic [IN_W-1:0] g,
                              input logic [IN_W-1:0] b);
        @(negedge clk);
        start     <= 1'b1;
        hdr_red   <= r;
        hdr_green <= g;
        hdr_blue  <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_ldr.push_back(tone_map(r, g, b));
        pixels_sent++;
    endtask

    // Start is held low for the number of cycles given, while the data ports carry noise that must be ignored.
    task automatic idle_burst(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start     <= 1'b0;
            hdr_red   <= IN_W'($urandom);
            hdr_green <= IN_W'($urandom);
            hdr_blue  <= IN_W'($urandom);
        end
    endtask

    // Full-range values are rare; most are shifted down so that the curve is not saturated.
    function automatic logic [IN_W-1:0] hdr_sample();
        logic [IN_W-1:0] raw;
        raw = IN_W'($urandom);
        if ($urandom_range(0, 7) == 0)
            return raw;
        return raw >> $urandom_range(0, IN_W - 1);
    endfunction

    task automatic test_corner_pixels();
        send_pixel(24'h000000, 24'h000000, 24'h000000);
        send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_pixel(24'h000001, 24'h000001, 24'h000001);
        send_pixel(24'h010000, 24'h010000, 24'h010000);
        send_pixel(24'h008000, 24'h008000, 24'h008000);
        send_pixel(24'h000100, 24'h000100, 24'h000100);
        send_pixel(24'h800000, 24'h800000, 24'h800000);
        send_pixel(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_pixel(24'h555555, 24'hAAAAAA, 24'h555555);
        send_pixel(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
        send_pixel(24'h002000, 24'h003000, 24'h001000);
        pixels_directed += 11;
    endtask

    // Pure primaries drive the other channels of the output matrix negative.
    task automatic test_primaries();
        send_pixel(24'hFFFFFF, 24'h000000, 24'h000000);
        send_pixel(24'h000000, 24'hFFFFFF, 24'h000000);
        send_pixel(24'h000000, 24'h000000, 24'hFFFFFF);
        send_pixel(24'h004000, 24'h000000, 24'h000000);
        send_pixel(24'h000000, 24'h004000, 24'h000000);
        send_pixel(24'h000000, 24'h000000, 24'h004000);
        send_pixel(24'h030000, 24'h000000, 24'h000000);
        pixels_directed += 7;
    endtask

    task automatic test_random_with_gaps(input int count);
        for (int i = 0; i < count; i++)
        begin
            // Runs of 32 items alternate between gappy and back-to-back traffic.
            if (((i / 32) % 2 == 0) && ($urandom_range(0, 2) == 0))
                idle_burst($urandom_range(1, 4));
            send_pixel(hdr_sample(), hdr_sample(), hdr_sample());
        end
    endtask

    task automatic test_random_back_to_back(input int count);
        logic [IN_W-1:0] grey;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                grey = hdr_sample();
                send_pixel(grey, grey, grey);
            end
            else
                send_pixel(hdr_sample(), hdr_sample(), hdr_sample());
        end
    endtask

    always @(posedge clk)
    begin : check_results
        ldr_pixel_t want;
        if (rst_n && done)
        begin
            if (pending_ldr.size() == 0)
                report_mismatch("result with no pixel outstanding", int'(ldr_red), -1);
            else
            begin
                want = pending_ldr.pop_front();
                if (ldr_red !== want.red)
                    report_mismatch("ldr_red", int'(ldr_red), int'(want.red));
                if (ldr_green !== want.green)
                    report_mismatch("ldr_green", int'(ldr_green), int'(want.green));
                if (ldr_blue !== want.blue)
                    report_mismatch("ldr_blue", int'(ldr_blue), int'(want.blue));
                pixels_checked++;
            end
        end
    end

    // Ends the run if neither side moves an item for too long.
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no activity for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        hdr_red         = '0;
        hdr_green       = '0;
        hdr_blue        = '0;
        pixels_sent     = 0;
        pixels_directed = 0;
        pixels_checked  = 0;
        mismatches      = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_pixels();
        test_primaries();
        test_random_with_gaps(600);
        test_random_back_to_back(340);

        @(negedge clk);
        start <= 1'b0;
        while (pending_ldr.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        $display("Sent %0d pixels (%0d directed corners and primaries, the rest random).",
                 pixels_sent, pixels_directed);
        $display("Checked %0d tone-mapped results, %0d mismatches.", pixels_checked, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
